// ----- rtl/tga565_pkg.sv -----
// ----------------------------------------------------------------------------
// tga565_pkg
// Beat types, header offsets and the RGB565 packing shared by the decoder.
// ----------------------------------------------------------------------------
package tga565_pkg;

    typedef logic [9:0] t_pos;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic [15:0] dest_column;
        logic [15:0] dest_row;
        logic        last_pixel;
    } t_out_beat;

    // pixel on its way to the output: either a literal color or a palette lookup
    typedef struct packed {
        logic        use_pal;
        logic [15:0] color;
        logic [15:0] column;
        logic [15:0] row;
        logic        last;
    } t_pix_meta;

    localparam int   HDR_BYTES      = 18;
    localparam t_pos POS_TYPE       = 10'd2;
    localparam t_pos POS_WIDTH_LO   = 10'd12;
    localparam t_pos POS_WIDTH_HI   = 10'd13;
    localparam t_pos POS_HEIGHT_LO  = 10'd14;
    localparam t_pos POS_HEIGHT_HI  = 10'd15;

    localparam logic [7:0] TYPE_MAPPED = 8'd1;

    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;
    localparam logic [1:0] PH_ALPHA = 2'd3;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// ----- rtl/tga_to_rgb565_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tga_to_rgb565_decoder_unit
// TGA byte stream to RGB565 pixels with destination column and flipped row.
// ----------------------------------------------------------------------------
// input channel: one file byte a beat (i_valid / o_ready / i_beat); mark the
// first byte of a file with first_byte to restart the parse.
// output channel: one pixel a beat (o_valid / i_ready / o_beat) with its
// RGB565 color, column, row counted from the bottom and a last-pixel flag.
// throughput: one byte a cycle unless the output stalls. header, palette,
// blue/green/red and trailing bytes give no beat; each index byte or alpha
// byte gives one. a pixel's palette read and lookup stage load as its last
// byte is taken; the output register then loads from the lookup stage
// once the output register is free or i_ready is high.
// palette bytes are written into the palette memory as they arrive; index
// lookups read it back through its single registered read port.
// reset: parse state clears and the block reads the next byte as byte 0 of
// a header; palette contents are undefined until loaded.
// stall: with i_ready low the output register holds, the lookup stage holds
// one more pixel, and o_ready drops once both are full.
// ----------------------------------------------------------------------------
module tga_to_rgb565_decoder_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tga565_pkg::t_in_beat  i_beat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tga565_pkg::t_out_beat o_beat
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic                  take;
    logic                  accept;
    logic                  emit;
    tga565_pkg::t_pix_meta meta;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [15:0]           wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [15:0]           rd_data;

    assign accept  = i_valid && take;
    assign o_ready = take;

    tga565_parser #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .AW              (AW)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (accept),
        .i_beat    (i_beat),
        .o_emit    (emit),
        .o_meta    (meta),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    tga565_palette_mem #(
        .ENTRIES (PALETTE_ENTRIES),
        .AW      (AW)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tga565_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (emit),
        .i_meta     (meta),
        .i_pal_data (rd_data),
        .i_ready    (i_ready),
        .o_take     (take),
        .o_valid    (o_valid),
        .o_beat     (o_beat)
    );

endmodule

// ----- rtl/tga565_palette_mem.sv -----
// ----------------------------------------------------------------------------
// tga565_palette_mem
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tga565_palette_mem #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [15:0]   o_rd_data
);

    logic [15:0] r_mem [0:ENTRIES-1];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds between reads so a stalled lookup keeps its color
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/tga565_parser.sv -----
// ----------------------------------------------------------------------------
// tga565_parser
// Header capture, palette load and pixel position tracking, one byte a beat.
// ----------------------------------------------------------------------------
module tga565_parser #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int AW              = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  tga565_pkg::t_in_beat  i_beat,
    output logic                  o_emit,
    output tga565_pkg::t_pix_meta o_meta,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [15:0]           o_wr_data,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr
);

    localparam int PAL_END = tga565_pkg::HDR_BYTES + 3 * PALETTE_ENTRIES;

    tga565_pkg::t_pos r_pos, n_pos;
    logic [7:0]       r_type, n_type;
    logic [15:0]      r_width, n_width;
    logic [15:0]      r_height, n_height;
    logic [7:0]       r_blue, n_blue;
    logic [7:0]       r_green, n_green;
    logic [7:0]       r_red, n_red;
    logic [1:0]       r_phase, n_phase;
    logic [15:0]      r_col, n_col;
    logic [15:0]      r_row, n_row;
    logic             r_done, n_done;
    logic [AW-1:0]    r_pal_idx, n_pal_idx;

    logic [7:0]  b;
    logic        pix_ok;
    logic        do_pixel;
    logic        last_col;
    logic        last_row;
    logic [15:0] pix_color;
    logic        pix_use_pal;

    assign b = i_beat.data_byte;

    always_comb begin
        n_pos     = r_pos;
        n_type    = r_type;
        n_width   = r_width;
        n_height  = r_height;
        n_blue    = r_blue;
        n_green   = r_green;
        n_red     = r_red;
        n_phase   = r_phase;
        n_col     = r_col;
        n_row     = r_row;
        n_done    = r_done;
        n_pal_idx = r_pal_idx;

        o_wr_en     = 1'b0;
        o_wr_addr   = r_pal_idx;
        o_wr_data   = '0;
        do_pixel    = 1'b0;
        pix_color   = '0;
        pix_use_pal = 1'b0;
        pix_ok      = 1'b0;

        if (i_take) begin
            // marker byte restarts the parse, palette contents survive
            if (i_beat.first_byte) begin
                n_pos     = '0;
                n_type    = '0;
                n_width   = '0;
                n_height  = '0;
                n_blue    = '0;
                n_green   = '0;
                n_red     = '0;
                n_phase   = tga565_pkg::PH_BLUE;
                n_col     = '0;
                n_row     = '0;
                n_done    = 1'b0;
                n_pal_idx = '0;
            end
            pix_ok = !n_done && (n_width != 16'd0) && (n_height != 16'd0);

            if (n_pos < 10'(tga565_pkg::HDR_BYTES)) begin
                unique case (n_pos)
                    tga565_pkg::POS_TYPE:      n_type          = b;
                    tga565_pkg::POS_WIDTH_LO:  n_width[7:0]    = b;
                    tga565_pkg::POS_WIDTH_HI:  n_width[15:8]   = b;
                    tga565_pkg::POS_HEIGHT_LO: n_height[7:0]   = b;
                    tga565_pkg::POS_HEIGHT_HI: n_height[15:8]  = b;
                    default: ;
                endcase
                n_pos = n_pos + 10'd1;
            end else if (n_type == tga565_pkg::TYPE_MAPPED && n_pos < 10'(PAL_END)) begin
                case (n_phase)
                    tga565_pkg::PH_BLUE: begin
                        n_blue  = b;
                        n_phase = tga565_pkg::PH_GREEN;
                    end
                    tga565_pkg::PH_GREEN: begin
                        n_green = b;
                        n_phase = tga565_pkg::PH_RED;
                    end
                    default: begin
                        n_red     = b;
                        o_wr_en   = 1'b1;
                        o_wr_addr = n_pal_idx;
                        o_wr_data = tga565_pkg::pack565(b, n_green, n_blue);
                        n_pal_idx = n_pal_idx + AW'(1);
                        n_phase   = tga565_pkg::PH_BLUE;
                    end
                endcase
                n_pos = n_pos + 10'd1;
            end else if (pix_ok) begin
                if (n_type == tga565_pkg::TYPE_MAPPED) begin
                    do_pixel = 1'b1;
                    // index past the palette reads as black
                    pix_use_pal = ({1'b0, b} < 9'(PALETTE_ENTRIES));
                end else begin
                    case (n_phase)
                        tga565_pkg::PH_BLUE: begin
                            n_blue  = b;
                            n_phase = tga565_pkg::PH_GREEN;
                        end
                        tga565_pkg::PH_GREEN: begin
                            n_green = b;
                            n_phase = tga565_pkg::PH_RED;
                        end
                        tga565_pkg::PH_RED: begin
                            n_red   = b;
                            n_phase = tga565_pkg::PH_ALPHA;
                        end
                        default: begin
                            n_phase   = tga565_pkg::PH_BLUE;
                            do_pixel  = 1'b1;
                            pix_color = tga565_pkg::pack565(n_red, n_green, n_blue);
                        end
                    endcase
                end
            end
        end

        last_col = ({1'b0, n_col} + 17'd1) >= {1'b0, n_width};
        last_row = ({1'b0, n_row} + 17'd1) >= {1'b0, n_height};

        o_meta.use_pal = pix_use_pal;
        o_meta.color   = pix_color;
        o_meta.column  = n_col;
        o_meta.row     = n_height - 16'd1 - n_row;
        o_meta.last    = last_col && last_row;

        if (do_pixel) begin
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_done = 1'b1;
                end else begin
                    n_row = n_row + 16'd1;
                end
            end else begin
                n_col = n_col + 16'd1;
            end
        end
    end

    assign o_emit    = do_pixel;
    assign o_rd_en   = do_pixel && pix_use_pal;
    assign o_rd_addr = b[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_type    <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_blue    <= '0;
            r_green   <= '0;
            r_red     <= '0;
            r_phase   <= tga565_pkg::PH_BLUE;
            r_col     <= '0;
            r_row     <= '0;
            r_done    <= 1'b0;
            r_pal_idx <= '0;
        end else begin
            r_pos     <= n_pos;
            r_type    <= n_type;
            r_width   <= n_width;
            r_height  <= n_height;
            r_blue    <= n_blue;
            r_green   <= n_green;
            r_red     <= n_red;
            r_phase   <= n_phase;
            r_col     <= n_col;
            r_row     <= n_row;
            r_done    <= n_done;
            r_pal_idx <= n_pal_idx;
        end
    end

    // byte position never runs past the end of the palette
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 10'(PAL_END))
        else $error("byte position beyond palette end");

    // a palette write and a pixel never come from the same byte
    a_wr_xor_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !o_emit)
        else $error("palette write and pixel on one byte");

    // a finished image leaves the column counter at zero
    a_done_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_col == 16'd0))
        else $error("column count not cleared at image end");

endmodule

// ----- rtl/tga565_out_stage.sv -----
// ----------------------------------------------------------------------------
// tga565_out_stage
// Lookup stage waiting on palette read data, then the output register.
// ----------------------------------------------------------------------------
module tga565_out_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  tga565_pkg::t_pix_meta  i_meta,
    input  logic [15:0]            i_pal_data,
    input  logic                   i_ready,
    output logic                   o_take,
    output logic                   o_valid,
    output tga565_pkg::t_out_beat  o_beat
);

    logic                  r_s1_vld;
    tga565_pkg::t_pix_meta r_s1_meta;
    logic                  r_out_vld;
    tga565_pkg::t_out_beat r_out;
    logic                  s1_move;
    tga565_pkg::t_out_beat s1_beat;

    assign s1_move = r_s1_vld && (!r_out_vld || i_ready);
    assign o_take  = !r_s1_vld || s1_move;

    always_comb begin
        s1_beat.pixel_color = r_s1_meta.use_pal ? i_pal_data : r_s1_meta.color;
        s1_beat.dest_column = r_s1_meta.column;
        s1_beat.dest_row    = r_s1_meta.row;
        s1_beat.last_pixel  = r_s1_meta.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_meta <= i_meta;
        end
        if (s1_move) begin
            r_out <= s1_beat;
        end
    end

    assign o_valid = r_out_vld;
    assign o_beat  = r_out;

    // lookup stage is only loaded when it is free or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_s1_vld || s1_move))
        else $error("lookup stage overwritten");

    // both stages full and receiver stalled: no new byte taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !i_ready) |-> !o_take)
        else $error("byte taken with pipeline full");

    // a beat leaving the lookup stage shows up at the output
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_vld)
        else $error("pixel lost between stages");

endmodule

// ----- test/tga_to_rgb565_decoder_unit_test.sv -----
// ----------------------------------------------------------------------------
// tga_to_rgb565_decoder_unit_test
// Streams TGA files byte by byte into the decoder: a short directed table, then
// random true-color and palette images of mostly small sizes, with restarts,
// truncated images and trailing bytes. Every accepted byte steps a local model
// of the parser, and each pixel beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tga_to_rgb565_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_BYTES   = 3 * PAL_ENTRIES;
    localparam int BYTE_TARGET = 1700;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    tga565_pkg::t_in_beat  i_beat;
    logic                  o_valid;
    logic                  i_ready;
    tga565_pkg::t_out_beat o_beat;

    tga_to_rgb565_decoder_unit #(
        .PALETTE_ENTRIES(PAL_ENTRIES)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_beat (i_beat),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_beat (o_beat)
    );

    // directed table: header with no start marker, one white pixel, two trailing bytes
    typedef struct {
        logic [7:0]            data;
        logic                  first;
        bit                    typed;
        tga565_pkg::t_out_beat pix;
    } t_dir_row;

    t_dir_row dir_rows [24] = '{
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{16'hFFFF, 16'd0, 16'd0, 1'b1}},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}
    };

    // parser state of the local model
    logic [9:0]  dec_pos;
    logic [7:0]  dec_type;
    logic [15:0] dec_width;
    logic [15:0] dec_height;
    logic [15:0] dec_palette [PAL_ENTRIES];
    logic [7:0]  dec_blue;
    logic [7:0]  dec_green;
    logic [7:0]  dec_red;
    logic [1:0]  dec_phase;
    logic [15:0] dec_col;
    logic [15:0] dec_row;
    logic        dec_done;

    tga565_pkg::t_out_beat pixel_queue [$];
    int                    fail_count;
    int                    bytes_sent;
    int                    src_idle_pct;
    int                    sink_stall_pct;
    int                    ready_hold_len;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [15:0] to_rgb565(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    task automatic clear_parser();
        dec_pos    = '0;
        dec_type   = '0;
        dec_width  = '0;
        dec_height = '0;
        dec_blue   = '0;
        dec_green  = '0;
        dec_red    = '0;
        dec_phase  = tga565_pkg::PH_BLUE;
        dec_col    = '0;
        dec_row    = '0;
        dec_done   = 1'b0;
    endtask

    task automatic place_pixel(input logic [15:0] color, output tga565_pkg::t_out_beat px);
        logic last_col;
        logic last_row;
        last_col = (32'(dec_col) + 1) >= 32'(dec_width);
        last_row = (32'(dec_row) + 1) >= 32'(dec_height);
        px.pixel_color = color;
        px.dest_column = dec_col;
        px.dest_row    = dec_height - 16'd1 - dec_row;
        px.last_pixel  = last_col && last_row;
        if (last_col) begin
            dec_col = '0;
            if (last_row)
                dec_done = 1'b1;
            else
                dec_row = dec_row + 16'd1;
        end else begin
            dec_col = dec_col + 16'd1;
        end
    endtask

    task automatic step_decoder(input tga565_pkg::t_in_beat ib, output bit has_px,
                                output tga565_pkg::t_out_beat px);
        logic [7:0] d;
        int         entry;
        d      = ib.data_byte;
        has_px = 1'b0;
        px     = '0;
        if (ib.first_byte)
            clear_parser();
        if (dec_pos < tga565_pkg::HDR_BYTES) begin
            case (dec_pos)
                tga565_pkg::POS_TYPE:      dec_type          = d;
                tga565_pkg::POS_WIDTH_LO:  dec_width[7:0]    = d;
                tga565_pkg::POS_WIDTH_HI:  dec_width[15:8]   = d;
                tga565_pkg::POS_HEIGHT_LO: dec_height[7:0]   = d;
                tga565_pkg::POS_HEIGHT_HI: dec_height[15:8]  = d;
                default: ;
            endcase
            dec_pos = dec_pos + 10'd1;
        end else if (dec_type == tga565_pkg::TYPE_MAPPED &&
                     dec_pos < tga565_pkg::HDR_BYTES + PAL_BYTES) begin
            case (dec_phase)
                tga565_pkg::PH_BLUE: begin
                    dec_blue  = d;
                    dec_phase = tga565_pkg::PH_GREEN;
                end
                tga565_pkg::PH_GREEN: begin
                    dec_green = d;
                    dec_phase = tga565_pkg::PH_RED;
                end
                default: begin
                    dec_red   = d;
                    entry     = (int'(dec_pos) - tga565_pkg::HDR_BYTES) / 3;
                    dec_palette[entry] = to_rgb565(dec_red, dec_green, dec_blue);
                    dec_phase = tga565_pkg::PH_BLUE;
                end
            endcase
            dec_pos = dec_pos + 10'd1;
        end else if (!dec_done && dec_width != 0 && dec_height != 0) begin
            if (dec_type == tga565_pkg::TYPE_MAPPED) begin
                has_px = 1'b1;
                place_pixel((int'(d) < PAL_ENTRIES) ? dec_palette[d] : 16'h0000, px);
            end else begin
                case (dec_phase)
                    tga565_pkg::PH_BLUE: begin
                        dec_blue  = d;
                        dec_phase = tga565_pkg::PH_GREEN;
                    end
                    tga565_pkg::PH_GREEN: begin
                        dec_green = d;
                        dec_phase = tga565_pkg::PH_RED;
                    end
                    tga565_pkg::PH_RED: begin
                        dec_red   = d;
                        dec_phase = tga565_pkg::PH_ALPHA;
                    end
                    default: begin
                        dec_phase = tga565_pkg::PH_BLUE;
                        has_px    = 1'b1;
                        place_pixel(to_rgb565(dec_red, dec_green, dec_blue), px);
                    end
                endcase
            end
        end
    endtask

    // drive one byte, hold it until taken, then step the model
    task automatic send_byte(input tga565_pkg::t_in_beat ib, input bit typed,
                             input tga565_pkg::t_out_beat typed_pix);
        bit                    has_px;
        tga565_pkg::t_out_beat px;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat  <= ib;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
        step_decoder(ib, has_px, px);
        if (typed)
            pixel_queue.push_back(typed_pix);
        else if (has_px)
            pixel_queue.push_back(px);
    endtask

    // sender goes idle until every expected pixel is out
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_image(input bit mapped, input bit marked, input logic [15:0] w,
                              input logic [15:0] h, input longint body_limit,
                              input int trail);
        logic [7:0] hdr [tga565_pkg::HDR_BYTES];
        longint     body;
        for (int k = 0; k < tga565_pkg::HDR_BYTES; k++)
            hdr[k] = 8'($urandom_range(0, 255));
        if (mapped)
            hdr[tga565_pkg::POS_TYPE] = tga565_pkg::TYPE_MAPPED;
        else if (hdr[tga565_pkg::POS_TYPE] == tga565_pkg::TYPE_MAPPED)
            hdr[tga565_pkg::POS_TYPE] = 8'h02;
        hdr[tga565_pkg::POS_WIDTH_LO]  = w[7:0];
        hdr[tga565_pkg::POS_WIDTH_HI]  = w[15:8];
        hdr[tga565_pkg::POS_HEIGHT_LO] = h[7:0];
        hdr[tga565_pkg::POS_HEIGHT_HI] = h[15:8];
        for (int k = 0; k < tga565_pkg::HDR_BYTES; k++)
            send_byte(tga565_pkg::t_in_beat'{hdr[k], marked && k == 0}, 1'b0, '0);
        if (mapped) begin
            for (int k = 0; k < PAL_BYTES; k++)
                send_byte(tga565_pkg::t_in_beat'{8'($urandom_range(0, 255)), 1'b0},
                          1'b0, '0);
        end
        body = longint'(w) * longint'(h);
        if (!mapped)
            body = body * 4;
        if (body > body_limit)
            body = body_limit;
        // a rare restart in the middle of the pixel data
        for (longint k = 0; k < body; k++)
            send_byte(tga565_pkg::t_in_beat'{8'($urandom_range(0, 255)),
                                             $urandom_range(399) == 0},
                      1'b0, '0);
        for (int k = 0; k < trail; k++)
            send_byte(tga565_pkg::t_in_beat'{8'($urandom_range(0, 255)), 1'b0}, 1'b0, '0);
    endtask

    // receive side: random stalls, plus a long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold_len > 0) begin
                ready_hold_len--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        tga565_pkg::t_out_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_queue.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected pixel beat, actual %h", $time, o_beat);
            end else begin
                want = pixel_queue.pop_front();
                if (o_beat.pixel_color !== want.pixel_color) begin
                    fail_count++;
                    $display("%0t: pixel_color expected %h actual %h", $time,
                             want.pixel_color, o_beat.pixel_color);
                end
                if (o_beat.dest_column !== want.dest_column) begin
                    fail_count++;
                    $display("%0t: dest_column expected %h actual %h", $time,
                             want.dest_column, o_beat.dest_column);
                end
                if (o_beat.dest_row !== want.dest_row) begin
                    fail_count++;
                    $display("%0t: dest_row expected %h actual %h", $time,
                             want.dest_row, o_beat.dest_row);
                end
                if (o_beat.last_pixel !== want.last_pixel) begin
                    fail_count++;
                    $display("%0t: last_pixel expected %b actual %b", $time,
                             want.last_pixel, o_beat.last_pixel);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int         cur_phase;
        int         new_phase;
        int         pick;
        bit         mapped;
        bit         mapped_pending;
        logic [15:0] w;
        logic [15:0] h;
        longint     limit;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_beat         = '0;
        fail_count     = 0;
        bytes_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        ready_hold_len = 0;
        clear_parser();
        foreach (dec_palette[k])
            dec_palette[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_byte(tga565_pkg::t_in_beat'{dir_rows[k].data, dir_rows[k].first},
                      dir_rows[k].typed, dir_rows[k].pix);
        wait_drain();

        // output held off long enough for the input to back up
        ready_hold_len = 200;
        send_image(1'b0, 1'b1, 16'd6, 16'd3, 64'd1 << 40, 0);
        wait_drain();

        bytes_sent     = 0;
        cur_phase      = 0;
        mapped_pending = 1'b1;
        while (bytes_sent < BYTE_TARGET) begin
            new_phase = bytes_sent * 4 / BYTE_TARGET;
            if (new_phase != cur_phase) begin
                wait_drain();
                cur_phase = new_phase;
                case (cur_phase)
                    1: begin
                        src_idle_pct   = 69;
                        sink_stall_pct = 0;
                    end
                    2: begin
                        src_idle_pct   = 0;
                        sink_stall_pct = 69;
                    end
                    default: begin
                        src_idle_pct   = 6;
                        sink_stall_pct = 6;
                    end
                endcase
            end
            mapped         = mapped_pending || $urandom_range(39) == 0;
            mapped_pending = 1'b0;
            limit          = 64'd1 << 40;
            pick           = $urandom_range(9);
            if (pick == 0) begin
                // empty image: zero width or zero height
                w = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 5));
                h = (w == 0) ? 16'($urandom_range(0, 4)) : 16'd0;
            end else if (pick == 1 && !mapped) begin
                w     = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
                h     = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
                limit = $urandom_range(0, 48);
            end else begin
                w = 16'($urandom_range(1, 5));
                h = 16'($urandom_range(1, 4));
            end
            send_image(mapped, $urandom_range(11) != 0, w, h, limit, $urandom_range(0, 3));
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pixel_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
